@@ hdl/assert_macros.svh @@
// concurrent assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("assertion failed");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)

`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

@@ hdl/pmr_pkg.sv @@
package pmr_pkg;

    localparam int FILE_W        = 48;
    localparam int PIECE_W       = 31;
    localparam int PROD_W        = 62;
    localparam int COUNT_W       = 9;
    localparam int IDX_W         = 8;
    localparam int MAX_FILES_DEF = 256;
    localparam int APB_AW        = 3;
    localparam int APB_DW        = 32;

    localparam logic [PIECE_W-1:0] PIECE_BYTES_RST = 31'd262144;
    localparam logic [COUNT_W-1:0] FILE_COUNT_RST  = 9'd1;

    localparam logic REG_PIECE_BYTES = 1'b0;
    localparam logic REG_FILE_COUNT  = 1'b1;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_SPAN,
        OP_RANGE,
        OP_LEN
    } op_t;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_FAIL,
        RES_LOAD,
        RES_LEN,
        RES_SPAN,
        RES_OVERLAP
    } res_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_TOTAL,
        ST_CHECK,
        ST_CLIP,
        ST_END,
        ST_SCAN,
        ST_BOUND,
        ST_OVERLAP,
        ST_DONE
    } state_t;

    typedef struct packed {
        op_t                 opcode;
        logic [IDX_W-1:0]    file_index;
        logic [PIECE_W-1:0]  piece_index;
        logic [FILE_W-1:0]   file_bytes;
    } req_t;

    typedef struct packed {
        logic                ok;
        logic [IDX_W-1:0]    first_file;
        logic [IDX_W-1:0]    last_file;
        logic [PIECE_W-1:0]  offset_in_piece;
        logic [FILE_W-1:0]   offset_in_file;
        logic [PIECE_W-1:0]  span_bytes;
    } rsp_t;

    typedef struct packed {
        logic    capture;
        logic    load_wr;
        logic    mul;
        logic    scan_start;
        logic    run;
        logic    total;
        logic    check;
        logic    clip;
        logic    end_calc;
        logic    match;
        logic    bound;
        res_op_t res_op;
        logic    push;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic scan_done;
        logic piece_ok;
        logic out_free;
    } status_t;

endpackage

@@ hdl/piece_to_file_range_mapper.sv @@
// channel   | valid      | stall      | payload          | direction
// request   | req_valid  | req_stall  | req_data (req_t) | in
// response  | rsp_valid  | rsp_stall  | rsp_data (rsp_t) | out
// config    | psel/penable/pwrite, paddr, pwdata, prdata, pready (apb)
//
// a load writes its table entry and goes straight to ST_DONE without a table scan
// queries scan the live files (file_count, capped at MAX_FILES) in the file length table,
// one entry per cycle: a length query or a failed piece takes one pass, span and range two
// reset: piece_bytes 262144, file_count 1, table contents undefined, no clearing pass
// the next request is accepted while a response waits; a finished request holds until
// rsp_stall drops
module piece_to_file_range_mapper
#(
    parameter int MAX_FILES = pmr_pkg::MAX_FILES_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  pmr_pkg::req_t                 req_data,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output pmr_pkg::rsp_t                 rsp_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pmr_pkg::APB_AW-1:0]    paddr,
    input  logic [pmr_pkg::APB_DW-1:0]    pwdata,
    output logic [pmr_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    import pmr_pkg::*;

    logic [PIECE_W-1:0] piece_bytes;
    logic [COUNT_W-1:0] file_count;
    cmd_t               cmd;
    status_t            status;

    pmr_regs u_regs
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .piece_bytes (piece_bytes),
        .file_count  (file_count)
    );

    pmr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    pmr_datapath
    #(
        .MAX_FILES (MAX_FILES)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_data    (req_data),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp_data    (rsp_data),
        .piece_bytes (piece_bytes),
        .file_count  (file_count),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

@@ hdl/pmr_regs.sv @@
module pmr_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pmr_pkg::APB_AW-1:0]    paddr,
    input  logic [pmr_pkg::APB_DW-1:0]    pwdata,
    output logic [pmr_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    output logic [pmr_pkg::PIECE_W-1:0]   piece_bytes,
    output logic [pmr_pkg::COUNT_W-1:0]   file_count
);
    import pmr_pkg::*;

    logic [PIECE_W-1:0] piece_bytes_reg;
    logic [COUNT_W-1:0] file_count_reg;
    logic               wr_en;
    logic               reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            piece_bytes_reg <= PIECE_BYTES_RST;
            file_count_reg  <= FILE_COUNT_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_PIECE_BYTES: piece_bytes_reg <= pwdata[PIECE_W-1:0];
                REG_FILE_COUNT:  file_count_reg  <= pwdata[COUNT_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_PIECE_BYTES: prdata = APB_DW'(piece_bytes_reg);
            REG_FILE_COUNT:  prdata = APB_DW'(file_count_reg);
            default:         prdata = '0;
        endcase
    end

    assign piece_bytes = piece_bytes_reg;
    assign file_count  = file_count_reg;

endmodule

@@ hdl/pmr_ctrl.sv @@
module pmr_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  pmr_pkg::status_t  status,
    output pmr_pkg::cmd_t     cmd
);
    import pmr_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_op = RES_NONE;
        req_stall  = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOAD;
                end
            end
            // first cycle after capture: split loads from queries
            ST_LOAD:
            begin
                if (status.op == OP_LOAD)
                begin
                    cmd.load_wr = 1'b1;
                    cmd.res_op  = RES_LOAD;
                    state_next  = ST_DONE;
                end
                else
                begin
                    cmd.mul        = 1'b1;
                    cmd.scan_start = 1'b1;
                    state_next     = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.run    = 1'b1;
                state_next = ST_TOTAL;
            end
            ST_TOTAL:
            begin
                cmd.run = 1'b1;
                if (status.scan_done)
                begin
                    cmd.total  = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = ST_CLIP;
            end
            ST_CLIP:
            begin
                if (!status.piece_ok)
                begin
                    cmd.res_op = RES_FAIL;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.clip   = 1'b1;
                    state_next = ST_END;
                end
            end
            ST_END:
            begin
                cmd.end_calc = 1'b1;
                if (status.op == OP_LEN)
                begin
                    cmd.res_op = RES_LEN;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.run   = 1'b1;
                cmd.match = 1'b1;
                if (status.scan_done)
                begin
                    state_next = ST_BOUND;
                end
            end
            ST_BOUND:
            begin
                cmd.bound = 1'b1;
                if (status.op == OP_SPAN)
                begin
                    cmd.res_op = RES_SPAN;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_OVERLAP;
                end
            end
            ST_OVERLAP:
            begin
                cmd.res_op = RES_OVERLAP;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/pmr_datapath.sv @@
`include "assert_macros.svh"

module pmr_datapath
#(
    parameter int MAX_FILES = pmr_pkg::MAX_FILES_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  pmr_pkg::req_t                 req_data,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output pmr_pkg::rsp_t                 rsp_data,
    input  logic [pmr_pkg::PIECE_W-1:0]   piece_bytes,
    input  logic [pmr_pkg::COUNT_W-1:0]   file_count,
    input  pmr_pkg::cmd_t                 cmd,
    output pmr_pkg::status_t              status
);
    import pmr_pkg::*;

    localparam int AW    = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
    localparam int CW    = $clog2(MAX_FILES + 1);
    localparam int SUM_W = FILE_W + $clog2(MAX_FILES);
    localparam int CMP_W = (SUM_W > PROD_W) ? SUM_W : PROD_W;

    // file length table
    logic [FILE_W-1:0] mem [MAX_FILES];

    req_t               req_reg;
    rsp_t               res_reg;
    rsp_t               res_next;
    rsp_t               rsp_data_reg;
    logic               out_valid_reg;

    logic [CW-1:0]      live_cnt;
    logic               load_ok;
    logic               issue;

    logic [CW-1:0]      rd_cnt_reg;
    logic               v1_reg;
    logic               v2_reg;
    logic [FILE_W-1:0]  rd_data_reg;
    logic [AW-1:0]      idx1_reg;
    logic [AW-1:0]      idx2_reg;
    logic [SUM_W-1:0]   acc_reg;
    logic [SUM_W-1:0]   lo2_reg;
    logic [SUM_W-1:0]   hi2_reg;

    logic [PROD_W-1:0]  prod_reg;
    logic [SUM_W-1:0]   t_reg;
    logic [SUM_W-1:0]   s_reg;
    logic [SUM_W-1:0]   diff_reg;
    logic [SUM_W-1:0]   e_reg;
    logic [PIECE_W-1:0] pspan_reg;
    logic               piece_ok_reg;

    logic               got_first_reg;
    logic               got_last_reg;
    logic               got_fi_reg;
    logic [AW-1:0]      first_reg;
    logic [AW-1:0]      last_reg;
    logic [SUM_W-1:0]   fs_reg;
    logic [SUM_W-1:0]   fe_reg;

    logic [SUM_W-1:0]   lo_reg;
    logic [SUM_W-1:0]   hi_reg;
    logic               range_ok_reg;

    logic               first_hit;
    logic               last_hit;
    logic               fi_hit;

    assign live_cnt = (32'(file_count) > 32'(MAX_FILES)) ? CW'(MAX_FILES) : CW'(file_count);
    assign load_ok  = 32'(req_reg.file_index) < 32'(MAX_FILES);
    assign issue    = cmd.run && (rd_cnt_reg < live_cnt);

    assign first_hit = !got_first_reg && (s_reg >= lo2_reg) && (s_reg < hi2_reg);
    assign last_hit  = (got_first_reg || first_hit) && !got_last_reg && (hi2_reg >= e_reg);
    assign fi_hit    = !got_fi_reg && (32'(idx2_reg) == 32'(req_reg.file_index));

    always_ff @(posedge clk)
    begin
        if (cmd.load_wr && load_ok)
        begin
            mem[AW'(req_reg.file_index)] <= req_reg.file_bytes;
        end
        rd_data_reg <= mem[rd_cnt_reg[AW-1:0]];
    end

    // scan control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_cnt_reg    <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            got_first_reg <= 1'b0;
            got_last_reg  <= 1'b0;
            got_fi_reg    <= 1'b0;
        end
        else if (cmd.scan_start)
        begin
            rd_cnt_reg    <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            got_first_reg <= 1'b0;
            got_last_reg  <= 1'b0;
            got_fi_reg    <= 1'b0;
        end
        else
        begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
            if (issue)
            begin
                rd_cnt_reg <= rd_cnt_reg + CW'(1);
            end
            if (cmd.match && v2_reg)
            begin
                if (first_hit)
                begin
                    got_first_reg <= 1'b1;
                end
                if (last_hit)
                begin
                    got_last_reg <= 1'b1;
                end
                if (fi_hit)
                begin
                    got_fi_reg <= 1'b1;
                end
            end
        end
    end

    // scan and arithmetic payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req_data;
        end
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(req_reg.piece_index) * PROD_W'(piece_bytes);
        end
        if (issue)
        begin
            idx1_reg <= rd_cnt_reg[AW-1:0];
        end
        if (cmd.scan_start)
        begin
            acc_reg <= '0;
        end
        else if (v1_reg)
        begin
            acc_reg  <= acc_reg + SUM_W'(rd_data_reg);
            lo2_reg  <= acc_reg;
            hi2_reg  <= acc_reg + SUM_W'(rd_data_reg);
            idx2_reg <= idx1_reg;
        end
        if (cmd.total)
        begin
            t_reg <= acc_reg;
        end
        if (cmd.check)
        begin
            piece_ok_reg <= (piece_bytes != '0) && (live_cnt != '0)
                            && (CMP_W'(prod_reg) < CMP_W'(t_reg));
            s_reg        <= SUM_W'(prod_reg);
            diff_reg     <= t_reg - SUM_W'(prod_reg);
        end
        if (cmd.clip)
        begin
            pspan_reg <= (diff_reg < SUM_W'(piece_bytes)) ? PIECE_W'(diff_reg) : piece_bytes;
        end
        if (cmd.end_calc)
        begin
            e_reg <= s_reg + SUM_W'(pspan_reg);
        end
        if (cmd.match && v2_reg)
        begin
            if (first_hit)
            begin
                first_reg <= idx2_reg;
            end
            if (last_hit)
            begin
                last_reg <= idx2_reg;
            end
            if (fi_hit)
            begin
                fs_reg <= lo2_reg;
                fe_reg <= hi2_reg;
            end
        end
        if (cmd.bound)
        begin
            lo_reg       <= (s_reg >= fs_reg) ? s_reg : fs_reg;
            hi_reg       <= (e_reg <= fe_reg) ? e_reg : fe_reg;
            range_ok_reg <= got_last_reg && got_fi_reg
                            && (32'(first_reg) <= 32'(req_reg.file_index))
                            && (32'(req_reg.file_index) <= 32'(last_reg));
        end
        res_reg <= res_next;
        if (cmd.push)
        begin
            rsp_data_reg <= res_reg;
        end
    end

    always_comb
    begin
        res_next = res_reg;
        unique case (cmd.res_op)
            RES_NONE:
            begin
                res_next = res_reg;
            end
            RES_FAIL:
            begin
                res_next = '0;
            end
            RES_LOAD:
            begin
                res_next    = '0;
                res_next.ok = load_ok;
            end
            RES_LEN:
            begin
                res_next            = '0;
                res_next.ok         = 1'b1;
                res_next.span_bytes = pspan_reg;
            end
            RES_SPAN:
            begin
                res_next = '0;
                if (got_last_reg)
                begin
                    res_next.ok         = 1'b1;
                    res_next.first_file = IDX_W'(first_reg);
                    res_next.last_file  = IDX_W'(last_reg);
                end
            end
            RES_OVERLAP:
            begin
                res_next = '0;
                if (range_ok_reg && (hi_reg > lo_reg))
                begin
                    res_next.ok              = 1'b1;
                    res_next.offset_in_piece = PIECE_W'(lo_reg - s_reg);
                    res_next.offset_in_file  = FILE_W'(lo_reg - fs_reg);
                    res_next.span_bytes      = PIECE_W'(hi_reg - lo_reg);
                end
            end
            default:
            begin
                res_next = '0;
            end
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = rsp_data_reg;

    assign status.op        = req_reg.opcode;
    assign status.scan_done = (rd_cnt_reg == live_cnt) && !v1_reg && !v2_reg;
    assign status.piece_ok  = piece_ok_reg;
    assign status.out_free  = !out_valid_reg || !rsp_stall;

    `ASSERT_PROP(a_push_when_free, clk, rst_n, cmd.push |-> (!out_valid_reg || !rsp_stall))
    `ASSERT_NEVER(a_last_needs_first, clk, rst_n, got_last_reg && !got_first_reg)
    `ASSERT_PROP(a_scan_in_bounds, clk, rst_n, cmd.match |-> (rd_cnt_reg <= live_cnt))
    `ASSERT_PROP(a_fail_is_clear, clk, rst_n, (rsp_valid && !rsp_data.ok) |-> (rsp_data.span_bytes == '0 && rsp_data.offset_in_file == '0 && rsp_data.first_file == '0))

endmodule
